FILE: src/piecewise_linear_pdf_sampler_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef PIECEWISE_LINEAR_PDF_SAMPLER_MACROS_SVH
`define PIECEWISE_LINEAR_PDF_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PLPDS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plpds assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PLPDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plpds assertion failed");

`endif

FILE: src/plpds_pkg.sv
package plpds_pkg;

    localparam int MAX_POINTS = 16;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int GUARD_BITS = 16;

    // Shared shift-subtract unit sizing
    localparam int SRC_W      = 130;
    localparam int REM_W      = 66;
    localparam int QUO_W      = 129;
    localparam int STEP_W     = 8;
    localparam int DIV1_STEPS = 129;
    localparam int DIV2_STEPS = 81;
    localparam int SQRT_STEPS = 64;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_ZERO_AREA = 2'd3
    } status_t;

    typedef enum logic {
        FN_ADD    = 1'b0,
        FN_SAMPLE = 1'b1
    } func_t;

    typedef enum logic {
        MODE_DIV  = 1'b0,
        MODE_SQRT = 1'b1
    } unit_mode_t;

    typedef enum logic {
        PASS_SUM  = 1'b0,
        PASS_WALK = 1'b1
    } pass_t;

    typedef struct packed {
        logic                 start;
        unit_mode_t           mode;
        logic [STEP_W-1:0]    steps;
        logic [SRC_W-1:0]     src;
        logic [63:0]          divisor;
    } unit_req_t;

    typedef struct packed {
        logic                 done;
        logic [QUO_W-1:0]     q;
    } unit_rsp_t;

    typedef struct packed {
        logic [31:0] dens;
        logic [31:0] pos;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CMP,
        S_SEG_RD0,
        S_SEG_LD0,
        S_SEG_LD1,
        S_SEG_MUL,
        S_SEG_ACC,
        S_LAST_RD,
        S_LAST_LD,
        S_R_MUL0,
        S_R_MUL1,
        S_R_ADD,
        S_K_MUL0,
        S_K_MUL1,
        S_D_MUL,
        S_DIV1_START,
        S_DIV1_WAIT,
        S_SQ_WAIT,
        S_DIV2_WAIT,
        S_DONE
    } state_t;

endpackage

FILE: src/plpds_ram.sv
module plpds_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/plpds_serial.sv
module plpds_serial
    import plpds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  unit_req_t req,
    output unit_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    unit_mode_t        mode_reg, mode_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [SRC_W-1:0]  src_reg, src_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  q_reg, q_next;
    logic [63:0]       div_reg, div_next;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    always_comb
    begin
        if (mode_reg == MODE_DIV)
        begin
            rem_sh = {rem_reg[REM_W-2:0], src_reg[SRC_W-1]};
            trial  = {2'b00, div_reg};
        end
        else
        begin
            rem_sh = {rem_reg[REM_W-3:0], src_reg[SRC_W-1:SRC_W-2]};
            trial  = {q_reg[63:0], 2'b01};
        end
        take = (rem_sh >= trial);

        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        src_next  = src_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        div_next  = div_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            mode_next = req.mode;
            cnt_next  = req.steps;
            src_next  = req.src;
            rem_next  = '0;
            q_next    = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // one quotient or root bit per cycle
            src_next = (mode_reg == MODE_DIV) ? {src_reg[SRC_W-2:0], 1'b0}
                                              : {src_reg[SRC_W-3:0], 2'b00};
            rem_next = take ? (rem_sh - trial) : rem_sh;
            q_next   = {q_reg[QUO_W-2:0], take};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        cnt_reg  <= cnt_next;
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        div_reg  <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule

FILE: src/piecewise_linear_pdf_sampler.sv
// Piecewise-linear density sampler.
// Slave channel s_axis: one transaction per item; tuser selects add (0) or
// sample (1); tdata carries position, density and uniform fraction.
// Master channel m_axis: one result transaction per item with the sampled
// position, a status code and the number of points held.
// Items are handled one at a time; s_axis_tready is high only while the
// sequencer is idle, and the next item can be taken in the cycle after a
// result is loaded. An add reads the point below its slot and moves it up
// while its position is greater, then writes the new point; a full-table add
// or an empty-table sample goes straight to the result. A sample walks the
// table segment by segment, twice when the area pass runs after the table
// changed, and when the quadratic is solved then runs a division, a square
// root and a second division in the one shared shift-subtract unit. One
// 32x32 multiplier and one table RAM, with one read and one write port, are
// shared by the steps that use them. Reset empties the table and clears the
// cached total area. If the receiver stalls, the finished result is held in
// the output register; a further item may be accepted and is held at its
// end until that result is taken.
module piecewise_linear_pdf_sampler
    import plpds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // point_position, point_density, uniform_fraction
    input  logic        s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // sample_value, status, point_total, zero pad
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              area_valid_reg, area_valid_next;
    logic [63:0]       area_reg, area_next;
    logic              m_valid_reg, m_valid_next;
    pass_t             pass_reg, pass_next;

    func_t             func_reg, func_next;
    logic [31:0]       in_pos_reg, in_pos_next;
    logic [31:0]       in_dens_reg, in_dens_next;
    logic [31:0]       u_reg, u_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [31:0]       p0_reg, p0_next, d0_reg, d0_next;
    logic [31:0]       p1_reg, p1_next, d1_reg, d1_next;
    logic [31:0]       last_pos_reg, last_pos_next;
    logic [63:0]       r_reg, r_next;
    logic [63:0]       lo_reg, lo_next;
    logic [95:0]       kr_reg, kr_next;
    logic [63:0]       base_reg, base_next;
    logic [31:0]       value_reg, value_next;
    status_t           status_reg, status_next;
    logic [31:0]       out_value_reg, out_value_next;
    status_t           out_status_reg, out_status_next;
    logic [CNT_W-1:0]  out_total_reg, out_total_next;

    logic [31:0]       mul_a, mul_b;
    logic [63:0]       prod_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    entry_t            ram_wdata, rd_e;
    logic [63:0]       ram_rdata;

    unit_req_t         ureq;
    unit_rsp_t         ursp;

    logic [CNT_W-1:0]  last;
    logic [CNT_W-1:0]  idx_ext;
    logic [31:0]       dx;
    logic [32:0]       dsum;
    logic [63:0]       seg_a;
    logic              rising;
    logic [31:0]       kmag;
    logic [127:0]      qs, bsh, disc;
    logic [63:0]       den;
    logic [80:0]       tq;
    logic [31:0]       offset;

    plpds_ram #(
        .WIDTH(64),
        .DEPTH(MAX_POINTS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    plpds_serial u_serial (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (ureq),
        .rsp  (ursp)
    );

    assign rd_e    = entry_t'(ram_rdata);
    assign last    = count_reg - CNT_W'(1);
    assign idx_ext = CNT_W'(idx_reg);
    assign dx      = p1_reg - p0_reg;
    assign dsum    = {1'b0, d0_reg} + {1'b0, d1_reg};
    assign seg_a   = prod_reg + (dsum[0] ? {33'b0, dx[31:1]} : 64'b0);
    assign rising  = (d1_reg >= d0_reg);
    assign kmag    = rising ? (d1_reg - d0_reg) : (d0_reg - d1_reg);
    assign qs      = ursp.q[127:0];
    assign bsh     = {32'b0, base_reg, 32'b0};
    assign disc    = rising ? (bsh + qs) : ((bsh < qs) ? 128'b0 : (bsh - qs));
    assign den     = {16'b0, d0_reg, 16'b0} + ursp.q[63:0];
    assign tq      = ursp.q[80:0];
    assign offset  = (tq > {49'b0, dx}) ? dx : tq[31:0];

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        area_valid_next = area_valid_reg;
        area_next       = area_reg;
        m_valid_next    = m_valid_reg;
        pass_next       = pass_reg;
        func_next       = func_reg;
        in_pos_next     = in_pos_reg;
        in_dens_next    = in_dens_reg;
        u_next          = u_reg;
        idx_next        = idx_reg;
        p0_next         = p0_reg;
        d0_next         = d0_reg;
        p1_next         = p1_reg;
        d1_next         = d1_reg;
        last_pos_next   = last_pos_reg;
        r_next          = r_reg;
        lo_next         = lo_reg;
        kr_next         = kr_reg;
        base_next       = base_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_total_next  = out_total_reg;

        mul_a     = '0;
        mul_b     = '0;
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '{dens: in_dens_reg, pos: in_pos_reg};
        ram_raddr = idx_reg;
        ureq      = '{start: 1'b0, mode: MODE_DIV, steps: '0, src: '0, divisor: '0};

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next    = func_t'(s_axis_tuser);
                    in_pos_next  = s_axis_tdata[31:0];
                    in_dens_next = s_axis_tdata[63:32];
                    u_next       = s_axis_tdata[95:64];
                    value_next   = '0;
                    status_next  = ST_OK;
                    if (func_t'(s_axis_tuser) == FN_ADD)
                    begin
                        if (count_reg >= CNT_W'(MAX_POINTS))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            idx_next        = count_reg[ADDR_W-1:0];
                            area_valid_next = 1'b0;
                            state_next      = S_ADD_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_DONE;
                    end
                    else if (!area_valid_reg)
                    begin
                        area_next  = '0;
                        pass_next  = PASS_SUM;
                        state_next = S_SEG_RD0;
                    end
                    else
                    begin
                        state_next = S_LAST_RD;
                    end
                end
            end

            S_ADD_RD:
            begin
                if (idx_reg == '0)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = idx_reg - ADDR_W'(1);
                    state_next = S_ADD_CMP;
                end
            end

            S_ADD_CMP:
            begin
                ram_we = 1'b1;
                if ($signed(rd_e.pos) > $signed(in_pos_reg))
                begin
                    // move the larger point up one slot
                    ram_wdata  = rd_e;
                    idx_next   = idx_reg - ADDR_W'(1);
                    state_next = S_ADD_RD;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_SEG_RD0:
            begin
                ram_raddr  = '0;
                idx_next   = '0;
                state_next = S_SEG_LD0;
            end

            S_SEG_LD0:
            begin
                p0_next = rd_e.pos;
                d0_next = rd_e.dens;
                if (last == '0)
                begin
                    area_valid_next = 1'b1;
                    state_next      = S_LAST_RD;
                end
                else
                begin
                    ram_raddr  = idx_reg + ADDR_W'(1);
                    state_next = S_SEG_LD1;
                end
            end

            S_SEG_LD1:
            begin
                p1_next    = rd_e.pos;
                d1_next    = rd_e.dens;
                state_next = S_SEG_MUL;
            end

            S_SEG_MUL:
            begin
                mul_a      = dx;
                mul_b      = dsum[32:1];
                state_next = S_SEG_ACC;
            end

            S_SEG_ACC:
            begin
                if (pass_reg == PASS_WALK && r_reg < seg_a)
                begin
                    if (dx == '0)
                    begin
                        value_next = p0_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_K_MUL0;
                    end
                end
                else
                begin
                    if (pass_reg == PASS_SUM)
                    begin
                        area_next = area_reg + seg_a;
                    end
                    else
                    begin
                        r_next = r_reg - seg_a;
                    end
                    p0_next  = p1_reg;
                    d0_next  = d1_reg;
                    idx_next = idx_reg + ADDR_W'(1);
                    if (idx_ext + CNT_W'(1) == last)
                    begin
                        if (pass_reg == PASS_SUM)
                        begin
                            area_valid_next = 1'b1;
                            state_next      = S_LAST_RD;
                        end
                        else
                        begin
                            // fraction past the end
                            value_next = last_pos_reg;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        ram_raddr  = idx_reg + ADDR_W'(2);
                        state_next = S_SEG_LD1;
                    end
                end
            end

            S_LAST_RD:
            begin
                ram_raddr  = last[ADDR_W-1:0];
                state_next = S_LAST_LD;
            end

            S_LAST_LD:
            begin
                last_pos_next = rd_e.pos;
                value_next    = rd_e.pos;
                if (area_reg == '0)
                begin
                    status_next = ST_ZERO_AREA;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_R_MUL0;
                end
            end

            S_R_MUL0:
            begin
                mul_a      = u_reg;
                mul_b      = area_reg[31:0];
                state_next = S_R_MUL1;
            end

            S_R_MUL1:
            begin
                lo_next    = prod_reg;
                mul_a      = u_reg;
                mul_b      = area_reg[63:32];
                state_next = S_R_ADD;
            end

            S_R_ADD:
            begin
                r_next     = prod_reg + {32'b0, lo_reg[63:32]};
                pass_next  = PASS_WALK;
                state_next = S_SEG_RD0;
            end

            S_K_MUL0:
            begin
                mul_a      = kmag;
                mul_b      = r_reg[31:0];
                state_next = S_K_MUL1;
            end

            S_K_MUL1:
            begin
                lo_next    = prod_reg;
                mul_a      = kmag;
                mul_b      = r_reg[63:32];
                state_next = S_D_MUL;
            end

            S_D_MUL:
            begin
                kr_next    = {prod_reg, 32'b0} + {32'b0, lo_reg};
                mul_a      = d0_reg;
                mul_b      = d0_reg;
                state_next = S_DIV1_START;
            end

            S_DIV1_START:
            begin
                base_next     = prod_reg;
                // 2*k*r*2^32 / dx, left aligned in the source word
                ureq.start    = 1'b1;
                ureq.mode     = MODE_DIV;
                ureq.steps    = STEP_W'(DIV1_STEPS);
                ureq.src      = {kr_reg, 1'b0, 32'b0, 1'b0};
                ureq.divisor  = {32'b0, dx};
                state_next    = S_DIV1_WAIT;
            end

            S_DIV1_WAIT:
            begin
                if (ursp.done)
                begin
                    ureq.start = 1'b1;
                    ureq.mode  = MODE_SQRT;
                    ureq.steps = STEP_W'(SQRT_STEPS);
                    ureq.src   = {disc, 2'b00};
                    state_next = S_SQ_WAIT;
                end
            end

            S_SQ_WAIT:
            begin
                if (ursp.done)
                begin
                    if (den == '0)
                    begin
                        value_next = p0_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ureq.start   = 1'b1;
                        ureq.mode    = MODE_DIV;
                        ureq.steps   = STEP_W'(DIV2_STEPS);
                        ureq.src     = {r_reg, 17'b0, 49'b0};
                        ureq.divisor = den;
                        state_next   = S_DIV2_WAIT;
                    end
                end
            end

            S_DIV2_WAIT:
            begin
                if (ursp.done)
                begin
                    value_next = p0_reg + offset;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_value_next  = value_reg;
                    out_status_next = status_reg;
                    out_total_next  = count_reg;
                    m_valid_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            area_valid_reg <= 1'b0;
            area_reg       <= '0;
            m_valid_reg    <= 1'b0;
            pass_reg       <= PASS_SUM;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            area_valid_reg <= area_valid_next;
            area_reg       <= area_next;
            m_valid_reg    <= m_valid_next;
            pass_reg       <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        in_pos_reg     <= in_pos_next;
        in_dens_reg    <= in_dens_next;
        u_reg          <= u_next;
        idx_reg        <= idx_next;
        p0_reg         <= p0_next;
        d0_reg         <= d0_next;
        p1_reg         <= p1_next;
        d1_reg         <= d1_next;
        last_pos_reg   <= last_pos_next;
        r_reg          <= r_next;
        lo_reg         <= lo_next;
        kr_reg         <= kr_next;
        base_reg       <= base_next;
        value_reg      <= value_next;
        status_reg     <= status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_total_reg  <= out_total_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, out_total_reg, out_status_reg, out_value_reg};

endmodule

FILE: src/plpds_checker.sv
`include "piecewise_linear_pdf_sampler_macros.svh"

module plpds_checker
    import plpds_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [95:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    `PLPDS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `PLPDS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `PLPDS_ASSERT_IMPL(a_empty_total, m_axis_tvalid && m_axis_tdata[33:32] == ST_EMPTY, m_axis_tdata[38:34] == '0 && m_axis_tdata[31:0] == '0)
    `PLPDS_ASSERT_IMPL(a_full_total, m_axis_tvalid && m_axis_tdata[33:32] == ST_FULL, m_axis_tdata[38:34] == 5'(MAX_POINTS))

endmodule

bind piecewise_linear_pdf_sampler plpds_checker u_plpds_checker (.*);

FILE: bench/tb_top.sv
module tb_top;
    import plpds_pkg::*;

    localparam int CYCLE_LIMIT = 8000000;
    localparam int LONG_HOLD   = 3000;

    typedef struct {
        func_t       func;
        logic [31:0] pos;
        logic [31:0] dens;
        logic [31:0] frac;
    } item_t;

    typedef struct {
        logic [31:0] value;
        status_t     status;
        logic [4:0]  total;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    piecewise_linear_pdf_sampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    item_t       pending_items[$];
    result_t     expected_results[$];
    item_t       offered;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_left;
    int          errors;
    int          cycles;

    // shadow of the point table
    logic [31:0] pos_tab[MAX_POINTS];
    logic [31:0] dens_tab[MAX_POINTS];
    int          point_count;
    logic [63:0] area_total;
    bit          area_cached;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] trapezoid_area(int i);
        logic [63:0] dx;
        logic [63:0] dsum;
        dx   = {32'b0, pos_tab[i + 1] - pos_tab[i]};
        dsum = {32'b0, dens_tab[i]} + {32'b0, dens_tab[i + 1]};
        return dx * (dsum >> 1) + (dsum[0] ? (dx >> 1) : 64'd0);
    endfunction

    function automatic logic [63:0] wide_isqrt(logic [127:0] x);
        logic [63:0]  root;
        logic [127:0] cand;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = {64'b0, root | (64'd1 << b)};
            if (cand * cand <= x)
                root = cand[63:0];
        end
        return root;
    endfunction

    // invert the quadratic in-segment CDF
    function automatic logic [31:0] segment_offset(int i, logic [63:0] r);
        logic [127:0] dx;
        logic [127:0] d0;
        logic [127:0] d1;
        logic [127:0] kmag;
        logic [127:0] prod;
        logic [127:0] quo;
        logic [127:0] rem;
        logic [127:0] qs;
        logic [127:0] base;
        logic [127:0] disc;
        logic [63:0]  den;
        logic [127:0] t;
        bit           rising;
        dx     = {96'b0, pos_tab[i + 1] - pos_tab[i]};
        d0     = {96'b0, dens_tab[i]};
        d1     = {96'b0, dens_tab[i + 1]};
        rising = d1 >= d0;
        kmag   = rising ? d1 - d0 : d0 - d1;
        if (dx == 0)
            return '0;
        prod = (kmag * {64'b0, r}) << 1;
        quo  = prod / dx;
        rem  = prod % dx;
        qs   = (quo << 32) + {64'b0, 64'((rem[63:0] << 32) / dx[63:0])};
        base = {64'b0, 64'(d0[63:0] * d0[63:0])} << 32;
        if (rising)
            disc = base + qs;
        else
            disc = (base < qs) ? '0 : base - qs;
        den = (d0[63:0] << GUARD_BITS) + wide_isqrt(disc);
        if (den == 0)
            return '0;
        t = ({64'b0, r} << (GUARD_BITS + 1)) / {64'b0, den};
        if (t > dx)
            return dx[31:0];
        return t[31:0];
    endfunction

    function automatic result_t predict_sample_or_insert(item_t it);
        result_t     res;
        int          slot;
        int          last;
        logic [63:0] r;
        logic [63:0] a;
        logic [95:0] prod;
        res.value  = '0;
        res.status = ST_OK;
        if (it.func == FN_ADD)
        begin
            if (point_count >= MAX_POINTS)
                res.status = ST_FULL;
            else
            begin
                slot = point_count;
                while (slot > 0 && $signed(pos_tab[slot - 1]) > $signed(it.pos))
                begin
                    pos_tab[slot]  = pos_tab[slot - 1];
                    dens_tab[slot] = dens_tab[slot - 1];
                    slot--;
                end
                pos_tab[slot]  = it.pos;
                dens_tab[slot] = it.dens;
                point_count++;
                area_cached = 1'b0;
            end
        end
        else if (point_count == 0)
            res.status = ST_EMPTY;
        else
        begin
            last = point_count - 1;
            if (!area_cached)
            begin
                area_total = '0;
                for (int i = 0; i < last; i++)
                    area_total += trapezoid_area(i);
                area_cached = 1'b1;
            end
            res.value = pos_tab[last];
            if (area_total == 0)
                res.status = ST_ZERO_AREA;
            else
            begin
                prod = {64'b0, it.frac} * {32'b0, area_total};
                r    = prod[95:32];
                for (int i = 0; i < last; i++)
                begin
                    a = trapezoid_area(i);
                    if (r >= a)
                        r -= a;
                    else
                    begin
                        res.value = pos_tab[i] + segment_offset(i, r);
                        break;
                    end
                end
            end
        end
        res.total = 5'(point_count);
        return res;
    endfunction

    // driver: record accepted transaction, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.insert(expected_results.size(),
                                        predict_sample_or_insert(offered));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= offered.func;
                    s_axis_tdata  <= {offered.frac, offered.dens, offered.pos};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check results and drive back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_res;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (m_axis_tdata[31:0] !== exp_res.value)
                    begin
                        $display("%0t: sample_value expected %h actual %h",
                                 $time, exp_res.value, m_axis_tdata[31:0]);
                        errors++;
                    end
                    if (m_axis_tdata[33:32] !== exp_res.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_res.status, m_axis_tdata[33:32]);
                        errors++;
                    end
                    if (m_axis_tdata[38:34] !== exp_res.total)
                    begin
                        $display("%0t: point_total expected %0d actual %0d",
                                 $time, exp_res.total, m_axis_tdata[38:34]);
                        errors++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic queue_item(func_t f, logic [31:0] p, logic [31:0] d, logic [31:0] u);
        item_t it;
        it.func = f;
        it.pos  = p;
        it.dens = d;
        it.frac = u;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic queue_random(int n);
        logic [31:0] p;
        for (int k = 0; k < n; k++)
        begin
            p = $urandom_range(3) == 0 ? $urandom() : 32'($signed($urandom_range(65535)) - 32768) << 8;
            if ($urandom_range(99) < 12)
                queue_item(FN_ADD, p, $urandom_range(1) ? $urandom() : $urandom_range(1 << 20),
                           $urandom());
            else
                queue_item(FN_SAMPLE, $urandom(), $urandom(), $urandom());
        end
    endtask

    task automatic drain();
        while (!(pending_items.size() == 0 && !s_axis_tvalid && expected_results.size() == 0))
            @(posedge clk);
    endtask

    initial
    begin
        errors         = 0;
        cycles         = 0;
        hold_left      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        point_count    = 0;
        area_total     = '0;
        area_cached    = 1'b0;
        rst_n          = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, single point, zero densities
        queue_item(FN_SAMPLE, 32'h0, 32'h0, 32'h8000_0000);
        queue_item(FN_ADD, 32'h0, 32'h0, 32'h0);
        queue_item(FN_SAMPLE, 32'h0, 32'h0, 32'h8000_0000);
        queue_item(FN_ADD, 32'h0001_0000, 32'h0, 32'hFFFF_FFFF);
        queue_item(FN_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678);
        // rising segment from zero density: zero denominator at zero fraction
        queue_item(FN_ADD, 32'h0002_0000, 32'h0001_0000, 32'h0);
        queue_item(FN_SAMPLE, 32'h0, 32'h0, 32'h0);
        queue_item(FN_SAMPLE, 32'h0, 32'h0, 32'h8000_0000);
        queue_item(FN_SAMPLE, 32'h0, 32'h0, 32'hFFFF_FFFF);
        // equal position, then a flat segment
        queue_item(FN_ADD, 32'h0002_0000, 32'h0003_0000, 32'h0);
        queue_item(FN_ADD, 32'h0003_0000, 32'h0003_0000, 32'h0);
        queue_item(FN_SAMPLE, 32'h0, 32'h0, 32'hC000_0000);
        queue_item(FN_SAMPLE, 32'h0, 32'h0, 32'hFFFF_FFFF);
        // extremes of position and density; falling segment at the top
        queue_item(FN_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
        queue_item(FN_ADD, 32'h7FFF_FFFF, 32'h0, 32'h0);
        queue_item(FN_SAMPLE, 32'h0, 32'h0, 32'h0);
        queue_item(FN_SAMPLE, 32'h0, 32'h0, 32'h0000_0001);
        queue_item(FN_SAMPLE, 32'h0, 32'h0, 32'h8000_0000);
        queue_item(FN_SAMPLE, 32'h0, 32'h0, 32'hFFFF_FFFF);
        hold_left = LONG_HOLD;
        drain();

        // sender pauses here until every result is in, phases follow
        queue_random(320);
        drain();
        send_idle_pct = 49;
        queue_random(320);
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 49;
        queue_random(320);
        drain();
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        queue_random(320);
        drain();

        repeat (500) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

FILE: files.f
+incdir+src
src/plpds_pkg.sv
src/plpds_ram.sv
src/plpds_serial.sv
src/piecewise_linear_pdf_sampler.sv
src/plpds_checker.sv
bench/tb_top.sv
